// ----- sv/intermittent_wiper_controller_unit_assert.svh -----
// Assertion macros for the wiper controller RTL.
`ifndef INTERMITTENT_WIPER_CONTROLLER_UNIT_ASSERT_SVH
`define INTERMITTENT_WIPER_CONTROLLER_UNIT_ASSERT_SVH

// Clocked check that is switched off while reset is asserted.
`define IWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define IWC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/iwc_pkg.sv -----
`timescale 1ns / 1ps

package iwc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEBOUNCE_MS   = 2'd0;
  localparam logic [1:0] CFG_INTERVAL_STEP = 2'd1;
  localparam logic [1:0] CFG_MS_PER_SECOND = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the configuration registers.
  localparam logic [15:0] DEBOUNCE_RST = 16'd250;
  localparam logic [4:0]  STEP_RST     = 5'd3;
  localparam logic [9:0]  MSPS_RST     = 10'd1000;

  typedef enum logic [1:0] {
    MODE_INTERVAL = 2'd0,
    MODE_SLOW     = 2'd1,
    MODE_FAST     = 2'd2
  } mode_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [4:0]  interval_step;
    logic [9:0]  ms_per_second;
  } cfg_t;

  typedef struct packed {
    logic       button_press;
    logic       zero_cross;
    logic       toggle_interval;
    logic       toggle_fast;
    logic [7:0] position_switches;
  } in_t;

  typedef struct packed {
    logic       motor_slow;
    logic       motor_fast;
    logic       status_led;
    logic [1:0] sweep_mode;
    logic [7:0] seconds_left;
  } out_t;

  // Highest set switch wins; with no switch set, position 8 is used.
  function automatic logic [3:0] sel_position(input logic [7:0] sw);
    logic [3:0] pos;
    pos = 4'd8;
    for (int k = 0; k < 8; k++) begin
      if (sw[k]) begin
        pos = 4'(k + 1);
      end
    end
    return pos;
  endfunction

endpackage

// ----- sv/iwc_cfg.sv -----
`timescale 1ns / 1ps

module iwc_cfg import iwc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_MS:   cfg_nxt.debounce_ms   = cfg_wdata;
        CFG_INTERVAL_STEP: cfg_nxt.interval_step = cfg_wdata[4:0];
        CFG_MS_PER_SECOND: cfg_nxt.ms_per_second = cfg_wdata[9:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms   <= DEBOUNCE_RST;
      cfg_r.interval_step <= STEP_RST;
      cfg_r.ms_per_second <= MSPS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/iwc_core.sv -----
`timescale 1ns / 1ps

module iwc_core import iwc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  in_t  item,
  input  cfg_t cfg,
  output out_t result
);

  logic [15:0] ms_count_r,   ms_count_nxt;
  logic [15:0] last_press_r, last_press_nxt;
  logic [9:0]  presc_r,      presc_nxt;
  logic        unit_on_r,    unit_on_nxt;
  mode_t       mode_r,       mode_nxt;
  logic [7:0]  pause_r,      pause_nxt;
  logic        slow_r,       slow_nxt;
  logic        fast_r,       fast_nxt;

  logic [15:0] elapsed;
  logic [9:0]  period;
  logic [9:0]  presc_inc;
  logic [8:0]  reload;

  assign elapsed   = ms_count_r - last_press_r;
  assign period    = (cfg.ms_per_second == '0) ? 10'd1 : cfg.ms_per_second;
  assign presc_inc = presc_r + 10'd1;
  assign reload    = cfg.interval_step * sel_position(item.position_switches);

  always_comb begin
    ms_count_nxt   = ms_count_r + 16'd1;
    last_press_nxt = last_press_r;
    unit_on_nxt    = unit_on_r;
    mode_nxt       = mode_r;
    pause_nxt      = pause_r;
    slow_nxt       = slow_r;
    fast_nxt       = fast_r;
    presc_nxt      = presc_inc;

    // An on/off press counts only once the debounce window has passed.
    if (item.button_press && (elapsed > cfg.debounce_ms)) begin
      last_press_nxt = ms_count_r;
      unit_on_nxt    = !unit_on_r;
    end

    // At park the motor stops when off or pausing between wipes.
    if (item.zero_cross && (!unit_on_nxt || mode_r == MODE_INTERVAL)) begin
      slow_nxt = 1'b0;
      fast_nxt = 1'b0;
    end

    if (presc_inc >= period) begin
      presc_nxt = '0;
      if (pause_r != '0) begin
        pause_nxt = pause_r - 8'd1;
      end
    end

    if (unit_on_nxt) begin
      if (item.toggle_interval) begin
        mode_nxt = MODE_INTERVAL;
      end else if (item.toggle_fast) begin
        mode_nxt = MODE_FAST;
      end else begin
        mode_nxt = MODE_SLOW;
      end

      case (mode_nxt)
        MODE_INTERVAL: begin
          if (pause_nxt == '0) begin
            pause_nxt = reload[7:0];
            slow_nxt  = 1'b1;
            fast_nxt  = 1'b0;
          end
        end
        MODE_FAST: begin
          slow_nxt = 1'b0;
          fast_nxt = 1'b1;
        end
        default: begin
          slow_nxt = 1'b1;
          fast_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_count_r   <= '0;
      last_press_r <= '0;
      presc_r      <= '0;
      unit_on_r    <= 1'b0;
      mode_r       <= MODE_SLOW;
      pause_r      <= '0;
      slow_r       <= 1'b0;
      fast_r       <= 1'b0;
    end else if (fire) begin
      ms_count_r   <= ms_count_nxt;
      last_press_r <= last_press_nxt;
      presc_r      <= presc_nxt;
      unit_on_r    <= unit_on_nxt;
      mode_r       <= mode_nxt;
      pause_r      <= pause_nxt;
      slow_r       <= slow_nxt;
      fast_r       <= fast_nxt;
    end
  end

  // The result reflects the state after this tick's update.
  always_comb begin
    result.motor_slow   = slow_nxt;
    result.motor_fast   = fast_nxt;
    result.status_led   = unit_on_nxt;
    result.sweep_mode   = mode_nxt;
    result.seconds_left = pause_nxt;
  end

endmodule

// ----- sv/intermittent_wiper_controller_unit.sv -----
`timescale 1ns / 1ps
// Intermittent wiper controller. Each input request is one millisecond tick that
// carries the button and park events, the mode toggles and the interval switch.
// Every accepted request yields exactly one output request with the motor drives,
// the on/off status, the current mode and the seconds left in the interval pause.
// Configuration (debounce time, interval step, ticks per second) is written through
// the cfg_ port; the user must write it only while no request is in flight, which
// the block does not enforce. Writes take effect on the next edge. An accepted
// request waits in the input register until the result register is free; its result
// is then registered and shown on out_ with out_valid high. Throughput is one
// request per cycle while out_stall is low, set by the single pass of tick logic
// between the input and result registers. When the receiver raises out_stall the
// result holds and in_stall is high while the input register is full; no request
// is dropped. A synchronous reset (rst_n low) clears both valid flags, turns the
// unit off in slow mode with motors stopped and restores the default configuration.

module intermittent_wiper_controller_unit import iwc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;
  in_t  in_item_r;
  logic in_vld_r,  in_vld_nxt;
  out_t out_r;
  logic out_vld_r, out_vld_nxt;
  out_t result;
  logic out_free;
  logic fire;
  logic in_take;

  // The result register can take a new value when empty or being drained.
  assign out_free = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign in_vld_nxt  = in_take || (in_vld_r && !fire);
  assign out_vld_nxt = fire || (out_vld_r && out_stall);

  iwc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  iwc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers load only when their stage advances.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
    if (fire) begin
      out_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`include "intermittent_wiper_controller_unit_assert.svh"

  // A processed tick always lands in the result register.
  `IWC_ASSERT(a_fire_shows, fire |=> out_vld_r, "processed tick did not reach the output")
  // A waiting tick is kept while the output side is blocked.
  `IWC_ASSERT(a_in_kept, (in_vld_r && !out_free) |=> in_vld_r, "waiting tick was dropped")
  // The two motor windings are never driven together.
  `IWC_ASSERT(a_one_winding, out_vld_r |-> !(out_r.motor_slow && out_r.motor_fast), "both driven")
  // Reset empties the result register.
  `IWC_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_vld_r, "output valid after reset")

endmodule

// ----- sim/tb_intermittent_wiper_controller_unit.sv -----
`timescale 1ns / 1ps

module tb_intermittent_wiper_controller_unit;
  import iwc_pkg::*;

  // The run is stopped if no request is accepted on either side for this many cycles in a row.
  localparam int WATCHDOG_LIMIT = 2000;
  // Longest idle stretch the sender inserts before one request.
  localparam int MAX_SEND_GAP   = 30;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Idle rates in percent per cycle for the sender and the receiver.
  int send_idle_pct;
  int recv_stall_pct;
  int mismatch_count;
  int quiet_cycles;

  // Outputs the controller owes us, oldest first.
  out_t pending_outputs[$];

  // Our own copy of the configuration registers.
  logic [15:0] debounce_cfg;
  logic [4:0]  step_cfg;
  logic [9:0]  ticks_per_sec_cfg;

  // Our own copy of the controller state.
  logic [15:0] ms_now;
  logic [15:0] last_press_at;
  logic [9:0]  sec_prescale;
  logic        unit_is_on;
  mode_t       cur_mode;
  logic [7:0]  pause_secs;
  logic        drive_slow;
  logic        drive_fast;

  intermittent_wiper_controller_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // State of the controller right after reset, configuration included.
  task automatic reset_wiper_state();
    debounce_cfg      = DEBOUNCE_RST;
    step_cfg          = STEP_RST;
    ticks_per_sec_cfg = MSPS_RST;
    ms_now            = '0;
    last_press_at     = '0;
    sec_prescale      = '0;
    unit_is_on        = 1'b0;
    cur_mode          = MODE_SLOW;
    pause_secs        = '0;
    drive_slow        = 1'b0;
    drive_fast        = 1'b0;
  endtask

  // Advances our copy of the controller by one millisecond tick and returns the
  // output request that the tick must produce. The steps run in the same order
  // as in the hardware: button, park, seconds countdown, mode and drive, then
  // the millisecond counter.
  function automatic out_t wiper_tick(input in_t t);
    logic [15:0] elapsed;
    logic [9:0]  period;
    int          pos;
    bit          found;
    out_t        r;
    // A press only counts once the wrapped time since the last accepted one
    // is strictly greater than the debounce window.
    if (t.button_press) begin
      elapsed = ms_now - last_press_at;
      if (elapsed > debounce_cfg) begin
        last_press_at = ms_now;
        unit_is_on    = !unit_is_on;
      end
    end
    // At park the motor stops when the unit is off or pausing in interval mode.
    if (t.zero_cross && (!unit_is_on || cur_mode == MODE_INTERVAL)) begin
      drive_slow = 1'b0;
      drive_fast = 1'b0;
    end
    // A tick count of zero per second behaves like one. The compare is "at or
    // above", so lowering the setting under the prescaler ends the second now.
    period       = (ticks_per_sec_cfg == 10'd0) ? 10'd1 : ticks_per_sec_cfg;
    sec_prescale = sec_prescale + 10'd1;
    if (sec_prescale >= period) begin
      sec_prescale = '0;
      if (pause_secs != 8'd0) begin
        pause_secs = pause_secs - 8'd1;
      end
    end
    // The mode only follows the toggles while the unit is on.
    if (unit_is_on) begin
      if (t.toggle_interval) begin
        cur_mode = MODE_INTERVAL;
      end else if (t.toggle_fast) begin
        cur_mode = MODE_FAST;
      end else begin
        cur_mode = MODE_SLOW;
      end
      case (cur_mode)
        MODE_INTERVAL: begin
          if (pause_secs == 8'd0) begin
            // The highest selected position wins; none selected means eight.
            pos   = 8;
            found = 1'b0;
            for (int k = 7; k >= 0; k--) begin
              if (!found && t.position_switches[k]) begin
                pos   = k + 1;
                found = 1'b1;
              end
            end
            pause_secs = 8'(int'(step_cfg) * pos);
            drive_slow = 1'b1;
            drive_fast = 1'b0;
          end
        end
        MODE_FAST: begin
          drive_slow = 1'b0;
          drive_fast = 1'b1;
        end
        default: begin
          drive_slow = 1'b1;
          drive_fast = 1'b0;
        end
      endcase
    end
    ms_now = ms_now + 16'd1;

    r.motor_slow   = drive_slow;
    r.motor_fast   = drive_fast;
    r.status_led   = unit_is_on;
    r.sweep_mode   = cur_mode;
    r.seconds_left = pause_secs;
    return r;
  endfunction

  function automatic in_t tick_in(input bit press, input bit park, input bit t_int,
                                  input bit t_fast, input logic [7:0] sw);
    in_t t;
    t.button_press      = press;
    t.zero_cross        = park;
    t.toggle_interval   = t_int;
    t.toggle_fast       = t_fast;
    t.position_switches = sw;
    return t;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // The receiver stalls at random; the rate is set per phase of the run.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Every accepted tick gets its expected output computed right away, and every
  // accepted output request is compared with the oldest one still owed. Both
  // handshakes are sampled at the edge, before any driver updates land.
  always @(posedge clk) begin : output_check
    out_t want;
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_outputs.size() == 0) begin
          $error("output request accepted with no tick waiting for it");
          mismatch_count++;
        end else begin
          want = pending_outputs.pop_front();
          check_field("motor_slow", 8'(want.motor_slow), 8'(out_data.motor_slow));
          check_field("motor_fast", 8'(want.motor_fast), 8'(out_data.motor_fast));
          check_field("status_led", 8'(want.status_led), 8'(out_data.status_led));
          check_field("sweep_mode", 8'(want.sweep_mode), 8'(out_data.sweep_mode));
          check_field("seconds_left", want.seconds_left, out_data.seconds_left);
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        pending_outputs.push_back(wiper_tick(in_data));
      end
    end
  end

  // Watchdog: the run is stuck if no request moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offers one tick, after a random idle stretch, and returns at the edge where
  // the controller takes it. in_valid stays high when the next tick follows
  // directly, so it is never lowered and raised in the same time step.
  task automatic send_tick(input in_t item);
    int gap;
    gap = 0;
    while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Stops sending and waits until every owed output has arrived. Each tick
  // produces exactly one output, so the controller is idle afterwards.
  task automatic settle_outputs();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_outputs.size() != 0);
  endtask

  // Register writes are only issued while the controller is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_DEBOUNCE_MS:   debounce_cfg      = value;
      CFG_INTERVAL_STEP: step_cfg          = value[4:0];
      CFG_MS_PER_SECOND: ticks_per_sec_cfg = value[9:0];
      default: ;
    endcase
  endtask

  task automatic set_idle_rates(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Mostly short debounce windows and fast seconds so that presses land and
  // the interval pause actually runs out within a phase.
  task automatic randomize_config();
    case ($urandom_range(7))
      0:       write_reg(CFG_DEBOUNCE_MS, 16'($urandom_range(60000, 65535)));
      1, 2:    write_reg(CFG_DEBOUNCE_MS, 16'd0);
      default: write_reg(CFG_DEBOUNCE_MS, 16'($urandom_range(1, 40)));
    endcase
    write_reg(CFG_INTERVAL_STEP, 16'($urandom_range(31)));
    if ($urandom_range(9) == 0) begin
      write_reg(CFG_MS_PER_SECOND, 16'($urandom_range(1023)));
    end else begin
      write_reg(CFG_MS_PER_SECOND, 16'($urandom_range(4)));
    end
  endtask

  // Special cases of the on/off and motor logic, one tick at a time.
  task automatic test_directed_cases();
    // Right after reset the default debounce window still covers this press,
    // and a park while off has nothing to stop.
    send_tick(tick_in(1, 0, 0, 0, 8'h00));
    send_tick(tick_in(0, 1, 0, 0, 8'hFF));
    settle_outputs();
    // Zero ticks per second behaves as one, so the pause drops every tick.
    write_reg(CFG_DEBOUNCE_MS, 16'd0);
    write_reg(CFG_INTERVAL_STEP, 16'd1);
    write_reg(CFG_MS_PER_SECOND, 16'd0);
    send_tick(tick_in(1, 0, 0, 0, 8'h00));  // switch on, slow
    send_tick(tick_in(0, 0, 0, 1, 8'h00));  // fast
    send_tick(tick_in(0, 1, 0, 1, 8'h00));  // park in fast keeps the motor running
    send_tick(tick_in(0, 1, 0, 0, 8'h00));  // park in slow keeps it running too
    send_tick(tick_in(0, 0, 1, 1, 8'h01));  // interval wins over fast, position one
    // The pause runs out on a park: the drive is cut, then reloaded at once.
    send_tick(tick_in(0, 1, 1, 0, 8'h01));
    send_tick(tick_in(0, 0, 1, 0, 8'hFF));  // several switches, the highest wins
    send_tick(tick_in(0, 1, 1, 0, 8'h80));
    send_tick(tick_in(1, 0, 1, 0, 8'h00));  // switch off, motor runs on
    send_tick(tick_in(0, 0, 0, 0, 8'h00));  // the pause keeps counting while off
    send_tick(tick_in(0, 1, 0, 1, 8'h55));  // park while off stops the motor
    send_tick(tick_in(1, 1, 1, 1, 8'hAA));  // everything at once
    settle_outputs();
    // A step of zero reloads a zero pause, so the wiper runs slow nonstop.
    write_reg(CFG_INTERVAL_STEP, 16'd0);
    send_tick(tick_in(0, 0, 1, 0, 8'h80));
    send_tick(tick_in(0, 1, 1, 0, 8'h80));
    send_tick(tick_in(0, 0, 1, 0, 8'h00));
    settle_outputs();
    // Largest step at the top position gives the longest pause.
    write_reg(CFG_INTERVAL_STEP, 16'd31);
    send_tick(tick_in(0, 0, 1, 0, 8'h80));
    send_tick(tick_in(0, 1, 1, 0, 8'h00));
    settle_outputs();
  endtask

  // Presses on every tick walk across the edge of the debounce window.
  task automatic test_debounce_window();
    write_reg(CFG_DEBOUNCE_MS, 16'd5);
    write_reg(CFG_MS_PER_SECOND, 16'd3);
    for (int i = 0; i < 20; i++) begin
      send_tick(tick_in(1, i[1], i[2], i[0], 8'($urandom)));
    end
    settle_outputs();
    // The widest window can never be exceeded by a 16-bit time difference.
    write_reg(CFG_DEBOUNCE_MS, 16'hFFFF);
    for (int i = 0; i < 8; i++) begin
      send_tick(tick_in(1, 0, 0, 0, 8'h00));
    end
    settle_outputs();
    // With no window at all every press toggles the unit.
    write_reg(CFG_DEBOUNCE_MS, 16'd0);
    for (int i = 0; i < 6; i++) begin
      send_tick(tick_in(1, i[0], 1, 0, 8'h04));
    end
    settle_outputs();
  endtask

  // Let the prescaler climb under a long second, then shorten the second well
  // below it: the next tick has to complete the second.
  task automatic test_prescaler_drop();
    write_reg(CFG_MS_PER_SECOND, 16'd1023);
    for (int i = 0; i < 40; i++) begin
      send_tick(tick_in(0, (i % 6) == 0, 1, 0, 8'h10));
    end
    settle_outputs();
    write_reg(CFG_MS_PER_SECOND, 16'd2);
    for (int i = 0; i < 6; i++) begin
      send_tick(tick_in(0, 0, 1, 0, 8'h10));
    end
    settle_outputs();
  endtask

  // Realistic operation: the driver holds the mode switches and the interval
  // switch for a while, the wiper parks at a steady sweep rate and the button
  // is pressed now and then. A share of the ticks is pure noise. Halfway the
  // sender stops until all outputs are in and the settings change.
  task automatic test_random_traffic(input int n_ticks);
    int         hold_left;
    int         sweep;
    bit         t_int;
    bit         t_fast;
    logic [7:0] sw;
    in_t        item;
    randomize_config();
    hold_left = 0;
    sweep     = 4;
    t_int     = 1'b0;
    t_fast    = 1'b0;
    sw        = '0;
    for (int i = 0; i < n_ticks; i++) begin
      if (i == n_ticks / 2) begin
        settle_outputs();
        randomize_config();
      end
      if (hold_left == 0) begin
        hold_left = $urandom_range(4, 30);
        t_int     = ($urandom_range(2) == 0);
        t_fast    = 1'($urandom_range(1));
        sweep     = $urandom_range(2, 8);
        case ($urandom_range(3))
          0:       sw = 8'h00;
          1:       sw = 8'h01 << $urandom_range(7);
          default: sw = 8'($urandom);
        endcase
      end
      hold_left--;
      if ($urandom_range(99) < 12) begin
        item = tick_in(1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom));
      end else begin
        item = tick_in($urandom_range(99) < 4, (i % sweep) == 0, t_int, t_fast, sw);
      end
      send_tick(item);
    end
    settle_outputs();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    set_idle_rates(10, 62);
    reset_wiper_state();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_debounce_window();
    test_prescaler_drop();
    test_random_traffic(150);
    set_idle_rates(62, 10);
    test_random_traffic(150);
    set_idle_rates(0, 0);
    test_random_traffic(150);

    // A tick passes through the input register and the result register; after settling, check that none is left owed.
    settle_outputs();
    repeat (10) @(posedge clk);
    if (pending_outputs.size() != 0) begin
      $error("%0d expected outputs never arrived", pending_outputs.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/iwc_pkg.sv
sv/iwc_cfg.sv
sv/iwc_core.sv
sv/intermittent_wiper_controller_unit.sv
sim/tb_intermittent_wiper_controller_unit.sv
